// ----- design/sorted_timeout_queue_defines.svh -----
// ----------------------------------------------------------------------------
// Sorted timeout queue: assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef SORTED_TIMEOUT_QUEUE_DEFINES_SVH
`define SORTED_TIMEOUT_QUEUE_DEFINES_SVH

// Same-cycle implication, sampled on i_clk and muted during reset.
`define STO_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sorted_timeout_queue: same-cycle check failed");

// Next-cycle implication, sampled on i_clk and muted during reset.
`define STO_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sorted_timeout_queue: next-cycle check failed");

`endif

// ----- design/sto_pkg.sv -----
// ----------------------------------------------------------------------------
// Sorted timeout queue package
// Sizes, codes and the command and status bundles between control and datapath.
// ----------------------------------------------------------------------------
package sto_pkg;

    localparam int ID_COUNT = 64;
    localparam int ID_W     = $clog2(ID_COUNT);
    localparam int CNT_W    = ID_W + 1;
    localparam int EXP_W    = 64;
    localparam int WORD_W   = 32;
    localparam int KIND_W   = 3;
    localparam int STAT_W   = 2;

    localparam logic [KIND_W-1:0] KIND_INSERT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_EXPIRE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_FETCH  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STAT_W-1:0] ST_NONE      = 2'd3;

    // Result staging operations.
    localparam logic [2:0] STG_KEEP  = 3'd0;
    localparam logic [2:0] STG_FULL  = 3'd1;
    localparam logic [2:0] STG_NF    = 3'd2;
    localparam logic [2:0] STG_NONE  = 3'd3;
    localparam logic [2:0] STG_NEWID = 3'd4;
    localparam logic [2:0] STG_EID   = 3'd5;
    localparam logic [2:0] STG_ORDQ  = 3'd6;
    localparam logic [2:0] STG_POP   = 3'd7;

    // Order memory read address select.
    localparam logic [2:0] ORS_NONE  = 3'd0;
    localparam logic [2:0] ORS_HEAD  = 3'd1;
    localparam logic [2:0] ORS_IDX   = 3'd2;
    localparam logic [2:0] ORS_IDXM1 = 3'd3;
    localparam logic [2:0] ORS_IDXP1 = 3'd4;
    localparam logic [2:0] ORS_POS   = 3'd5;

    // Order memory write data select.
    localparam logic [1:0] OWS_NONE  = 2'd0;
    localparam logic [1:0] OWS_ORDQ  = 2'd1;
    localparam logic [1:0] OWS_NEWID = 2'd2;

    // Walk index operations.
    localparam logic [2:0] IDX_HOLD  = 3'd0;
    localparam logic [2:0] IDX_CLR   = 3'd1;
    localparam logic [2:0] IDX_LOAD  = 3'd2;
    localparam logic [2:0] IDX_INC   = 3'd3;
    localparam logic [2:0] IDX_DEC   = 3'd4;

    typedef struct packed {
        logic       accept;
        logic [2:0] stage;
        logic [2:0] ord_rd;
        logic [1:0] ord_wr;
        logic [2:0] idx_op;
        logic       slot_rd;
        logic       ins_take;
        logic       ins_done;
        logic       rem_done;
        logic       pop;
        logic       head_load;
        logic       head_empty;
        logic       clear;
        logic       emit;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic count_zero;
        logic idx_zero;
        logic idx_at_count;
        logic idx_last;
        logic match;
        logic ge;
        logic due;
        logic pos_ok;
        logic out_free;
        logic res_fired;
    } t_sts;

endpackage

// ----- design/sto_dp.sv -----
// ----------------------------------------------------------------------------
// Sorted timeout queue datapath
// Slot, order and free-id memories, queue pointers and the result register.
// ----------------------------------------------------------------------------
module sto_dp import sto_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    input  logic [EXP_W-1:0]  i_expiry,
    input  logic [WORD_W-1:0] i_callback_handle,
    input  logic [WORD_W-1:0] i_user_data,
    input  logic [ID_W-1:0]   i_entry_id,
    input  logic [EXP_W-1:0]  i_now_time,
    input  logic [ID_W-1:0]   i_position,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [STAT_W-1:0] o_status,
    output logic [ID_W-1:0]   o_result_id,
    output logic [WORD_W-1:0] o_result_callback,
    output logic [WORD_W-1:0] o_result_data,
    output logic              o_fired,
    output logic [EXP_W-1:0]  o_earliest_expiry,
    output logic [ID_W-1:0]   o_occupancy,
    output logic              o_last
);

    // Latched command word.
    logic [EXP_W-1:0]  r_expiry;
    logic [WORD_W-1:0] r_cb;
    logic [WORD_W-1:0] r_data;
    logic [ID_W-1:0]   r_eid;
    logic [EXP_W-1:0]  r_now;
    logic [ID_W-1:0]   r_pos;

    // Queue state.
    logic [ID_W-1:0]   r_idx;
    logic [ID_W-1:0]   r_base;
    logic [ID_W-1:0]   r_count;
    logic [ID_W-1:0]   r_free_head;
    logic [CNT_W-1:0]  r_free_cnt;
    logic [EXP_W-1:0]  r_head_exp;
    logic [ID_W-1:0]   r_new_id;

    // Memories and their registered read data.
    logic [ID_W-1:0]   m_order [ID_COUNT];
    logic [EXP_W-1:0]  m_exp   [ID_COUNT];
    logic [WORD_W-1:0] m_cb    [ID_COUNT];
    logic [WORD_W-1:0] m_dat   [ID_COUNT];
    logic [ID_W-1:0]   m_free  [ID_COUNT];
    logic [ID_COUNT-1:0] r_free_vld;
    logic [ID_W-1:0]   r_ord_q;
    logic [EXP_W-1:0]  r_slot_exp_q;
    logic [WORD_W-1:0] r_slot_cb_q;
    logic [WORD_W-1:0] r_slot_dat_q;
    logic [ID_W-1:0]   r_free_mq;
    logic              r_free_vq;
    logic [ID_W-1:0]   r_free_dq;

    // Staged result.
    logic [STAT_W-1:0] r_stg_status;
    logic [ID_W-1:0]   r_stg_id;
    logic              r_stg_fired;
    logic [WORD_W-1:0] r_stg_cb;
    logic [WORD_W-1:0] r_stg_dat;

    // Output register.
    logic              r_out_vld;
    logic [STAT_W-1:0] r_o_status;
    logic [ID_W-1:0]   r_o_id;
    logic [WORD_W-1:0] r_o_cb;
    logic [WORD_W-1:0] r_o_dat;
    logic              r_o_fired;
    logic [EXP_W-1:0]  r_o_exp;
    logic [ID_W-1:0]   r_o_occ;
    logic              r_o_last;

    logic [ID_W-1:0]   w_free_q;
    logic [ID_W-1:0]   w_ord_raddr;
    logic [ID_W-1:0]   w_ord_waddr;
    logic [ID_W-1:0]   w_push_addr;
    logic [ID_W-1:0]   w_push_id;
    logic              w_push;
    logic              w_due;

    // An entry the free list never wrote back yields its default id, its index plus one.
    assign w_free_q    = r_free_vq ? r_free_mq : r_free_dq;
    assign w_ord_waddr = r_base + r_idx;
    assign w_push_addr = r_free_head + r_free_cnt[ID_W-1:0];
    assign w_push      = i_cmd.pop || i_cmd.rem_done;
    assign w_push_id   = i_cmd.pop ? r_ord_q : r_eid;
    assign w_due       = (r_count != '0) && (r_head_exp <= r_now);

    always_comb begin
        case (i_cmd.ord_rd)
            ORS_HEAD:  w_ord_raddr = r_base;
            ORS_IDX:   w_ord_raddr = r_base + r_idx;
            ORS_IDXM1: w_ord_raddr = r_base + r_idx - ID_W'(1);
            ORS_IDXP1: w_ord_raddr = r_base + r_idx + ID_W'(1);
            ORS_POS:   w_ord_raddr = r_base + r_pos;
            default:   w_ord_raddr = r_base;
        endcase
    end

    always_comb begin
        o_sts.full         = (r_free_cnt == '0) || (r_count >= ID_W'(ID_COUNT - 1));
        o_sts.count_zero   = (r_count == '0);
        o_sts.idx_zero     = (r_idx == '0);
        o_sts.idx_at_count = (r_idx >= r_count);
        o_sts.idx_last     = ({1'b0, r_idx} + CNT_W'(1)) >= {1'b0, r_count};
        o_sts.match        = (r_ord_q == r_eid);
        o_sts.ge           = (r_slot_exp_q >= r_expiry);
        o_sts.due          = w_due;
        o_sts.pos_ok       = (r_pos < r_count);
        o_sts.out_free     = !r_out_vld || !i_stall;
        o_sts.res_fired    = r_stg_fired;
    end

    // Memories.
    always_ff @(posedge i_clk) begin
        if (i_cmd.ord_rd != ORS_NONE) begin
            r_ord_q <= m_order[w_ord_raddr];
        end
        if (i_cmd.ord_wr == OWS_ORDQ) begin
            m_order[w_ord_waddr] <= r_ord_q;
        end else if (i_cmd.ord_wr == OWS_NEWID) begin
            m_order[w_ord_waddr] <= r_new_id;
        end
        if (i_cmd.slot_rd) begin
            r_slot_exp_q <= m_exp[r_ord_q];
            r_slot_cb_q  <= m_cb[r_ord_q];
            r_slot_dat_q <= m_dat[r_ord_q];
        end
        if (i_cmd.ins_take) begin
            m_exp[w_free_q] <= r_expiry;
            m_cb[w_free_q]  <= r_cb;
            m_dat[w_free_q] <= r_data;
        end
        r_free_mq <= m_free[r_free_head];
        r_free_vq <= r_free_vld[r_free_head];
        r_free_dq <= r_free_head + ID_W'(1);
        if (w_push) begin
            m_free[w_push_addr] <= w_push_id;
        end
    end

    // Control state of the queue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_base      <= '0;
            r_count     <= '0;
            r_free_head <= '0;
            r_free_cnt  <= CNT_W'(ID_COUNT - 1);
            r_free_vld  <= '0;
            r_head_exp  <= '1;
            r_out_vld   <= 1'b0;
        end else begin
            case (i_cmd.idx_op)
                IDX_CLR:  r_idx <= '0;
                IDX_LOAD: r_idx <= r_count;
                IDX_INC:  r_idx <= r_idx + ID_W'(1);
                IDX_DEC:  r_idx <= r_idx - ID_W'(1);
                default:  r_idx <= r_idx;
            endcase
            if (i_cmd.clear) begin
                r_count     <= '0;
                r_free_head <= '0;
                r_free_cnt  <= CNT_W'(ID_COUNT - 1);
                r_free_vld  <= '0;
                r_head_exp  <= '1;
            end else begin
                if (i_cmd.ins_take) begin
                    r_free_head <= r_free_head + ID_W'(1);
                    r_free_cnt  <= r_free_cnt - CNT_W'(1);
                end
                if (i_cmd.ins_done) begin
                    r_count <= r_count + ID_W'(1);
                end
                if (w_push) begin
                    r_count                 <= r_count - ID_W'(1);
                    r_free_cnt              <= r_free_cnt + CNT_W'(1);
                    r_free_vld[w_push_addr] <= 1'b1;
                end
                if (i_cmd.pop) begin
                    r_base <= r_base + ID_W'(1);
                end
                if (i_cmd.head_load) begin
                    r_head_exp <= r_slot_exp_q;
                end else if (i_cmd.head_empty) begin
                    r_head_exp <= '1;
                end
            end
            if (i_cmd.emit) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_expiry     <= i_expiry;
            r_cb         <= i_callback_handle;
            r_data       <= i_user_data;
            r_eid        <= i_entry_id;
            r_now        <= i_now_time;
            r_pos        <= i_position;
            r_stg_status <= ST_OK;
            r_stg_id     <= '0;
            r_stg_fired  <= 1'b0;
            r_stg_cb     <= '0;
            r_stg_dat    <= '0;
        end else begin
            case (i_cmd.stage)
                STG_FULL:  r_stg_status <= ST_FULL;
                STG_NF:    r_stg_status <= ST_NOT_FOUND;
                STG_NONE:  r_stg_status <= ST_NONE;
                STG_NEWID: r_stg_id     <= w_free_q;
                STG_EID:   r_stg_id     <= r_eid;
                STG_ORDQ:  r_stg_id     <= r_ord_q;
                STG_POP: begin
                    r_stg_id    <= r_ord_q;
                    r_stg_fired <= 1'b1;
                    r_stg_cb    <= r_slot_cb_q;
                    r_stg_dat   <= r_slot_dat_q;
                end
                default: r_stg_id <= r_stg_id;
            endcase
        end
        if (i_cmd.ins_take) begin
            r_new_id <= w_free_q;
        end
        if (i_cmd.emit) begin
            r_o_status <= r_stg_status;
            r_o_id     <= r_stg_id;
            r_o_cb     <= r_stg_cb;
            r_o_dat    <= r_stg_dat;
            r_o_fired  <= r_stg_fired;
            r_o_exp    <= r_head_exp;
            r_o_occ    <= r_count;
            r_o_last   <= !(r_stg_fired && w_due);
        end
    end

    assign o_valid           = r_out_vld;
    assign o_status          = r_o_status;
    assign o_result_id       = r_o_id;
    assign o_result_callback = r_o_cb;
    assign o_result_data     = r_o_dat;
    assign o_fired           = r_o_fired;
    assign o_earliest_expiry = r_o_exp;
    assign o_occupancy       = r_o_occ;
    assign o_last            = r_o_last;

endmodule

// ----- design/sto_ctrl.sv -----
// ----------------------------------------------------------------------------
// Sorted timeout queue controller
// Sequences the memory walks of each command and the result hand-off.
// ----------------------------------------------------------------------------
module sto_ctrl import sto_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [KIND_W-1:0] i_kind,
    output logic              o_stall,
    input  t_sts              i_sts,
    output t_cmd              o_cmd
);

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_INS_CHK  = 5'd1;
    localparam logic [4:0] S_INS_STEP = 5'd2;
    localparam logic [4:0] S_INS_ORD  = 5'd3;
    localparam logic [4:0] S_INS_CMP  = 5'd4;
    localparam logic [4:0] S_REM_CHK  = 5'd5;
    localparam logic [4:0] S_REM_CMP  = 5'd6;
    localparam logic [4:0] S_SHF_CHK  = 5'd7;
    localparam logic [4:0] S_SHF_WR   = 5'd8;
    localparam logic [4:0] S_FET_CHK  = 5'd9;
    localparam logic [4:0] S_FET_WAIT = 5'd10;
    localparam logic [4:0] S_EXP_CHK  = 5'd11;
    localparam logic [4:0] S_EXP_ORD  = 5'd12;
    localparam logic [4:0] S_EXP_SLOT = 5'd13;
    localparam logic [4:0] S_HD_START = 5'd14;
    localparam logic [4:0] S_HD_ORD   = 5'd15;
    localparam logic [4:0] S_HD_SLOT  = 5'd16;
    localparam logic [4:0] S_CLR      = 5'd17;
    localparam logic [4:0] S_EMIT     = 5'd18;

    logic [4:0] r_state;
    logic [4:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    o_cmd.idx_op = IDX_CLR;
                    case (i_kind)
                        KIND_INSERT: n_state = S_INS_CHK;
                        KIND_REMOVE: n_state = S_REM_CHK;
                        KIND_EXPIRE: n_state = S_EXP_CHK;
                        KIND_FETCH:  n_state = S_FET_CHK;
                        KIND_CLEAR:  n_state = S_CLR;
                        default:     n_state = S_EMIT;
                    endcase
                end
            end
            S_INS_CHK: begin
                if (i_sts.full) begin
                    o_cmd.stage = STG_FULL;
                    n_state     = S_EMIT;
                end else begin
                    o_cmd.ins_take = 1'b1;
                    o_cmd.stage    = STG_NEWID;
                    o_cmd.idx_op   = IDX_LOAD;
                    n_state        = S_INS_STEP;
                end
            end
            S_INS_STEP: begin
                if (i_sts.idx_zero) begin
                    o_cmd.ord_wr   = OWS_NEWID;
                    o_cmd.ins_done = 1'b1;
                    n_state        = S_HD_START;
                end else begin
                    o_cmd.ord_rd = ORS_IDXM1;
                    n_state      = S_INS_ORD;
                end
            end
            S_INS_ORD: begin
                o_cmd.slot_rd = 1'b1;
                n_state       = S_INS_CMP;
            end
            S_INS_CMP: begin
                if (i_sts.ge) begin
                    o_cmd.ord_wr = OWS_ORDQ;
                    o_cmd.idx_op = IDX_DEC;
                    n_state      = S_INS_STEP;
                end else begin
                    o_cmd.ord_wr   = OWS_NEWID;
                    o_cmd.ins_done = 1'b1;
                    n_state        = S_HD_START;
                end
            end
            S_REM_CHK: begin
                if (i_sts.idx_at_count) begin
                    o_cmd.stage = STG_NF;
                    n_state     = S_EMIT;
                end else begin
                    o_cmd.ord_rd = ORS_IDX;
                    n_state      = S_REM_CMP;
                end
            end
            S_REM_CMP: begin
                if (i_sts.match) begin
                    o_cmd.stage = STG_EID;
                    n_state     = S_SHF_CHK;
                end else begin
                    o_cmd.idx_op = IDX_INC;
                    n_state      = S_REM_CHK;
                end
            end
            S_SHF_CHK: begin
                if (i_sts.idx_last) begin
                    o_cmd.rem_done = 1'b1;
                    n_state        = S_HD_START;
                end else begin
                    o_cmd.ord_rd = ORS_IDXP1;
                    n_state      = S_SHF_WR;
                end
            end
            S_SHF_WR: begin
                o_cmd.ord_wr = OWS_ORDQ;
                o_cmd.idx_op = IDX_INC;
                n_state      = S_SHF_CHK;
            end
            S_FET_CHK: begin
                if (i_sts.pos_ok) begin
                    o_cmd.ord_rd = ORS_POS;
                    n_state      = S_FET_WAIT;
                end else begin
                    o_cmd.stage = STG_NF;
                    n_state     = S_EMIT;
                end
            end
            S_FET_WAIT: begin
                o_cmd.stage = STG_ORDQ;
                n_state     = S_EMIT;
            end
            S_EXP_CHK: begin
                if (i_sts.due) begin
                    o_cmd.ord_rd = ORS_HEAD;
                    n_state      = S_EXP_ORD;
                end else begin
                    o_cmd.stage = STG_NONE;
                    n_state     = S_EMIT;
                end
            end
            S_EXP_ORD: begin
                o_cmd.slot_rd = 1'b1;
                n_state       = S_EXP_SLOT;
            end
            S_EXP_SLOT: begin
                o_cmd.stage = STG_POP;
                o_cmd.pop   = 1'b1;
                n_state     = S_HD_START;
            end
            S_HD_START: begin
                if (i_sts.count_zero) begin
                    o_cmd.head_empty = 1'b1;
                    n_state          = S_EMIT;
                end else begin
                    o_cmd.ord_rd = ORS_HEAD;
                    n_state      = S_HD_ORD;
                end
            end
            S_HD_ORD: begin
                o_cmd.slot_rd = 1'b1;
                n_state       = S_HD_SLOT;
            end
            S_HD_SLOT: begin
                o_cmd.head_load = 1'b1;
                n_state         = S_EMIT;
            end
            S_CLR: begin
                o_cmd.clear = 1'b1;
                n_state     = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = (i_sts.res_fired && i_sts.due) ? S_EXP_CHK : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ----- design/sorted_timeout_queue.sv -----
// ----------------------------------------------------------------------------
// Sorted timeout queue
// Pending timeouts kept in expiry order, ids drawn from a free-id FIFO.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake          | Word
//  --------+-----------+--------------------+-----------------------------------
//  command | in        | i_valid / o_stall  | kind, expiry, handle, data, id, ...
//  result  | out       | o_valid / i_stall  | status, id, callback, data, ...
//
// How long a command takes, counting the accepting cycle, depends on its kind
// and on the walk over the single-port order memory and the slot memory
// behind it. An insert walks over each entry it moves past, a remove over
// each entry scanned and each entry shifted, and an expire over each popped
// entry; an expire with nothing due, a fetch and a clear walk no entries.
// Reset is synchronous and active low; it empties the queue and restores the
// free-id FIFO at once, with no clearing pass.
// o_stall is high whenever a command is in progress. A result that finds the
// previous one still stalled holds the block in its emit step until that one
// is taken; a new command is accepted while the last result of the previous
// one still waits.
//
// The order of pending ids lives in a ring: popping the head only advances a
// base pointer, while insert and remove shift the entries behind their spot.
// The earliest expiry is re-read from the memories after every insert, remove
// and pop, so each result reports the head as it stands after that result.

`include "sorted_timeout_queue_defines.svh"

module sorted_timeout_queue import sto_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [KIND_W-1:0] i_kind,
    input  logic [EXP_W-1:0]  i_expiry,
    input  logic [WORD_W-1:0] i_callback_handle,
    input  logic [WORD_W-1:0] i_user_data,
    input  logic [ID_W-1:0]   i_entry_id,
    input  logic [EXP_W-1:0]  i_now_time,
    input  logic [ID_W-1:0]   i_position,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [STAT_W-1:0] o_status,
    output logic [ID_W-1:0]   o_result_id,
    output logic [WORD_W-1:0] o_result_callback,
    output logic [WORD_W-1:0] o_result_data,
    output logic              o_fired,
    output logic [EXP_W-1:0]  o_earliest_expiry,
    output logic [ID_W-1:0]   o_occupancy,
    output logic              o_last
);

    t_cmd w_cmd;
    t_sts w_sts;

    // The controller only decides the order of memory steps; all queue state and
    // the result register sit in the datapath.
    sto_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_kind  (i_kind),
        .o_stall (o_stall),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    sto_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_expiry          (i_expiry),
        .i_callback_handle (i_callback_handle),
        .i_user_data       (i_user_data),
        .i_entry_id        (i_entry_id),
        .i_now_time        (i_now_time),
        .i_position        (i_position),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_status          (o_status),
        .o_result_id       (o_result_id),
        .o_result_callback (o_result_callback),
        .o_result_data     (o_result_data),
        .o_fired           (o_fired),
        .o_earliest_expiry (o_earliest_expiry),
        .o_occupancy       (o_occupancy),
        .o_last            (o_last)
    );

    // An empty queue always reports an all-ones earliest expiry.
    `STO_ASSERT_IMPL(a_empty_head, o_valid && (o_occupancy == '0), o_earliest_expiry == '1)
    // A popped entry always carries a real id and status ok.
    `STO_ASSERT_IMPL(a_fired_ok, o_valid && o_fired, (o_status == ST_OK) && (o_result_id != '0))
    // While an expire still has more entries to hand out, the block stays busy.
    `STO_ASSERT_IMPL(a_pop_busy, o_valid && o_fired && !o_last, o_stall)
    // Every accepted command makes the block busy in the next cycle.
    `STO_ASSERT_NEXT(a_accept_busy, i_valid && !o_stall, o_stall)

endmodule
